// ----- sv/oate_pkg.sv -----
// ----------------------------------------------------------------------------
// oate_pkg
// request codes, status codes and sequencer states of the ordered array table
// ----------------------------------------------------------------------------
`default_nettype none

package oate_pkg;

    typedef enum logic [2:0] {
        REQ_PUSH   = 3'd0,
        REQ_INSERT = 3'd1,
        REQ_POP    = 3'd2,
        REQ_DELETE = 3'd3,
        REQ_REMOVE = 3'd4,
        REQ_FIND   = 3'd5,
        REQ_READ   = 3'd6
    } t_req;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_EMPTY = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

endpackage

`default_nettype wire

// ----- sv/oate_ram.sv -----
// ----------------------------------------------------------------------------
// oate_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module oate_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- sv/ordered_array_table_engine.sv -----
// ----------------------------------------------------------------------------
// ordered_array_table_engine
// fixed-capacity table of signed words in arrival order: push, insert, pop,
// delete, remove all, find and read, walked one memory word per cycle
// ----------------------------------------------------------------------------
//
//  channel   | handshake            | payload
//  ----------+----------------------+------------------------------------------
//  request   | start / busy         | i_req_type, i_elem_index, i_value
//  result    | o_done (one cycle)   | o_status, o_read_value, o_found,
//            |                      | o_found_index, o_removed_count,
//            |                      | o_count_after, o_is_empty
//
//  an item is taken at an edge with start high and busy low; one result per
//  item follows, strobed by o_done for a single cycle; busy is still high during
//  the strobe and drops after it. words read per item: 0 for push, errors and the
//  unused code, 1 for pop and read, count - index for insert, count - index - 1
//  for delete, count for find and remove all; one ram read per cycle sets the pace
//  reset clears the count and the sequencer; no ram word at or above the count
//  is ever used, so the ram needs no clearing
//  the receiver cannot stall, so the result is never held
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_array_table_engine
    import oate_pkg::*;
#(
    parameter int CAPACITY  = 256,
    parameter int WORD_BITS = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         i_req_type,
    input  wire logic [7:0]         i_elem_index,
    input  wire logic signed [31:0] i_value,
    output logic                    o_done,
    output logic [1:0]              o_status,
    output logic signed [31:0]      o_read_value,
    output logic                    o_found,
    output logic [7:0]              o_found_index,
    output logic [8:0]              o_removed_count,
    output logic [8:0]              o_count_after,
    output logic                    o_is_empty
);

    // address, count and compare widths
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > 8) ? CW : 8;

    // sequencer
    t_state r_state, n_state;

    // table count and the request held for the walk
    logic [CW-1:0]        r_count, n_count;
    logic [2:0]           r_op, n_op;
    logic [AW-1:0]        r_idx, n_idx;
    logic [WORD_BITS-1:0] r_key, n_key;
    t_status              r_status, n_status;

    // walk control: read pointer, reads left, direction, last read address
    logic [AW-1:0]        r_rp, n_rp;
    logic [CW-1:0]        r_left, n_left;
    logic                 r_down, n_down;
    logic [AW-1:0]        r_ra, n_ra;
    logic                 r_dv, n_dv;

    // results gathered during the walk; r_wp is the compaction write pointer
    logic [WORD_BITS-1:0] r_rd, n_rd;
    logic                 r_found, n_found;
    logic [AW-1:0]        r_fidx, n_fidx;
    logic [CW-1:0]        r_removed, n_removed;
    logic [CW-1:0]        r_wp, n_wp;

    // ram ports
    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [WORD_BITS-1:0] w_wdata;
    logic [WORD_BITS-1:0] w_q;

    // request decode helpers
    logic                 w_accept;
    logic [XW-1:0]        w_idx_x;
    logic [XW-1:0]        w_cnt_x;
    logic [63:0]          w_val64;
    logic                 w_full;
    logic [CW-1:0]        w_count_fin;
    logic                 w_ok;
    logic                 w_match;

    oate_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_rp),
        .o_rdata (w_q)
    );

    assign w_accept = start && (r_state == S_IDLE);
    assign w_idx_x  = XW'(i_elem_index);
    assign w_cnt_x  = XW'(r_count);
    assign w_val64  = 64'($unsigned(i_value));
    assign w_full   = (r_count >= CW'(CAPACITY));
    assign w_ok     = (r_status == STAT_OK);
    assign w_match  = (w_q == r_key);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // last word read was processed this cycle
                if (r_left == '0) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // count after the request, valid in the finish cycle
    always_comb begin
        w_count_fin = r_count;
        if (w_ok) begin
            case (r_op) inside
                REQ_PUSH, REQ_INSERT: w_count_fin = r_count + 1'b1;
                REQ_POP, REQ_DELETE:  w_count_fin = r_count - 1'b1;
                REQ_REMOVE:           w_count_fin = r_wp;
                default:              w_count_fin = r_count;
            endcase
        end
    end

    // request setup, walk datapath and ram write port
    always_comb begin
        n_count   = r_count;
        n_op      = r_op;
        n_idx     = r_idx;
        n_key     = r_key;
        n_status  = r_status;
        n_rp      = r_rp;
        n_left    = r_left;
        n_down    = r_down;
        n_ra      = r_ra;
        n_dv      = 1'b0;
        n_rd      = r_rd;
        n_found   = r_found;
        n_fidx    = r_fidx;
        n_removed = r_removed;
        n_wp      = r_wp;
        w_we      = 1'b0;
        w_waddr   = r_ra;
        w_wdata   = w_q;

        if (w_accept) begin
            n_op      = i_req_type;
            n_idx     = AW'(i_elem_index);
            n_key     = WORD_BITS'(w_val64);
            n_status  = STAT_OK;
            n_left    = '0;
            n_down    = 1'b0;
            n_rp      = '0;
            n_rd      = '0;
            n_found   = 1'b0;
            n_fidx    = '0;
            n_removed = '0;
            n_wp      = '0;
            case (i_req_type) inside
                REQ_PUSH: begin
                    if (w_full) begin
                        n_status = STAT_FULL;
                    end
                end
                REQ_INSERT: begin
                    if (w_idx_x > w_cnt_x) begin
                        n_status = STAT_RANGE;
                    end else if (w_full) begin
                        n_status = STAT_FULL;
                    end else begin
                        // tail moves right, walked from the top down
                        n_left = CW'(w_cnt_x - w_idx_x);
                        n_rp   = AW'(r_count - 1'b1);
                        n_down = 1'b1;
                    end
                end
                REQ_POP: begin
                    if (r_count == '0) begin
                        n_status = STAT_EMPTY;
                    end else begin
                        n_left = CW'(1);
                        n_rp   = AW'(r_count - 1'b1);
                    end
                end
                REQ_DELETE: begin
                    if (w_idx_x >= w_cnt_x) begin
                        n_status = STAT_RANGE;
                    end else begin
                        // tail moves left, walked from just past the hole
                        n_left = CW'(w_cnt_x - w_idx_x - 1'b1);
                        n_rp   = AW'(w_idx_x + 1'b1);
                    end
                end
                REQ_REMOVE, REQ_FIND: begin
                    n_left = r_count;
                end
                REQ_READ: begin
                    if (w_idx_x >= w_cnt_x) begin
                        n_status = STAT_RANGE;
                    end else begin
                        n_left = CW'(1);
                        n_rp   = AW'(i_elem_index);
                    end
                end
                default: begin
                    n_status = STAT_OK;
                end
            endcase
        end

        if (r_state == S_SCAN) begin
            // issue the next read
            if (r_left != '0) begin
                n_dv   = 1'b1;
                n_ra   = r_rp;
                n_left = r_left - 1'b1;
                n_rp   = r_down ? (r_rp - 1'b1) : (r_rp + 1'b1);
            end
            // handle the word read in the previous cycle
            if (r_dv) begin
                case (r_op) inside
                    REQ_INSERT: begin
                        w_we    = 1'b1;
                        w_waddr = r_ra + 1'b1;
                    end
                    REQ_DELETE: begin
                        w_we    = 1'b1;
                        w_waddr = r_ra - 1'b1;
                    end
                    REQ_REMOVE: begin
                        if (w_match) begin
                            n_removed = r_removed + 1'b1;
                        end else begin
                            w_we    = 1'b1;
                            w_waddr = AW'(r_wp);
                            n_wp    = r_wp + 1'b1;
                        end
                    end
                    REQ_FIND: begin
                        if (!r_found && w_match) begin
                            n_found = 1'b1;
                            n_fidx  = r_ra;
                        end
                    end
                    REQ_POP, REQ_READ: begin
                        n_rd = w_q;
                    end
                    default: begin
                        w_we = 1'b0;
                    end
                endcase
            end
        end

        if (r_state == S_FINISH) begin
            // new word lands at the end for push, in the opened slot for insert
            if (w_ok && (r_op == REQ_PUSH)) begin
                w_we    = 1'b1;
                w_waddr = AW'(r_count);
                w_wdata = r_key;
            end else if (w_ok && (r_op == REQ_INSERT)) begin
                w_we    = 1'b1;
                w_waddr = r_idx;
                w_wdata = r_key;
            end
            n_count = w_count_fin;
        end
    end

    // outputs
    always_comb begin
        busy            = (r_state != S_IDLE);
        o_done          = (r_state == S_FINISH);
        o_status        = r_status;
        o_read_value    = 32'(r_rd);
        o_found         = r_found;
        o_found_index   = 8'(r_fidx);
        o_removed_count = 9'(r_removed);
        o_count_after   = 9'(w_count_fin);
        o_is_empty      = (w_count_fin == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_dv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_dv    <= n_dv;
        end
        r_op      <= n_op;
        r_idx     <= n_idx;
        r_key     <= n_key;
        r_status  <= n_status;
        r_rp      <= n_rp;
        r_left    <= n_left;
        r_down    <= n_down;
        r_ra      <= n_ra;
        r_rd      <= n_rd;
        r_found   <= n_found;
        r_fidx    <= n_fidx;
        r_removed <= n_removed;
        r_wp      <= n_wp;
    end

endmodule

`default_nettype wire

// ----- verif/ordered_array_table_engine_tb.sv -----
// ----------------------------------------------------------------------------
// ordered_array_table_engine_tb
// self-checking bench for the ordered array table: a cycle-free table model
// predicts every reply, directed items cover the empty and full corners and
// the word extremes, then a long weighted random mix drives the table up and
// down while the request side works in bursts with random gaps
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module ordered_array_table_engine_tb;
    import oate_pkg::*;

    localparam int          TABLE_DEPTH  = 256;
    localparam int          RESET_CYCLES = 6;
    // drain wait covers the longest walk, a full-table find or remove, with margin
    localparam int          DRAIN_CYCLES = TABLE_DEPTH + 16;
    // no item taken and no reply for this long means the block is stuck
    localparam int          STALL_LIMIT  = 4000;
    localparam int          MIX_ITEMS    = 1350;
    // request code the block treats as a no-op
    localparam logic [2:0]  REQ_NONE     = 3'd7;

    // one expected reply, field for field as on the result ports
    typedef struct {
        t_status            status;
        logic signed [31:0] read_value;
        logic               found;
        logic [7:0]         found_index;
        logic [8:0]         removed_count;
        logic [8:0]         count_after;
        logic               is_empty;
    } t_table_reply;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic [2:0]             i_req_type;
    logic [7:0]             i_elem_index;
    logic signed [31:0]     i_value;
    logic                   o_done;
    logic [1:0]             o_status;
    logic signed [31:0]     o_read_value;
    logic                   o_found;
    logic [7:0]             o_found_index;
    logic [8:0]             o_removed_count;
    logic [8:0]             o_count_after;
    logic                   o_is_empty;

    // shadow copy of the table contents and fill level
    logic signed [31:0]     tbl_words [TABLE_DEPTH];
    int unsigned            tbl_count;

    t_table_reply           table_reply_q[$];
    int unsigned            mismatches;

    // sender pacing: items go out in bursts, gaps between bursts when enabled
    int unsigned            burst_left;
    bit                     gaps_on;

    // keys that repeat often so find and remove actually hit something
    logic signed [31:0]     key_pool [8] = '{
        32'sh0000_0000, -32'sd1, 32'sh7fff_ffff, 32'sh8000_0000,
        32'sd1, 32'sd42, -32'sd42, 32'sh5555_aaaa
    };

    ordered_array_table_engine #(
        .CAPACITY  (TABLE_DEPTH),
        .WORD_BITS (32)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_req_type      (i_req_type),
        .i_elem_index    (i_elem_index),
        .i_value         (i_value),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_read_value    (o_read_value),
        .o_found         (o_found),
        .o_found_index   (o_found_index),
        .o_removed_count (o_removed_count),
        .o_count_after   (o_count_after),
        .o_is_empty      (o_is_empty)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // table model: applies one request to the shadow table, returns the reply
    // ------------------------------------------------------------------------
    function automatic t_table_reply table_apply(logic [2:0] kind, logic [7:0] idx,
                                                 logic signed [31:0] word);
        t_table_reply r;
        int unsigned  keep;
        r.status        = STAT_OK;
        r.read_value    = '0;
        r.found         = 1'b0;
        r.found_index   = '0;
        r.removed_count = '0;
        keep            = 0;
        case (kind)
            REQ_PUSH: begin
                if (tbl_count >= TABLE_DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    tbl_words[tbl_count] = word;
                    tbl_count++;
                end
            end
            REQ_INSERT: begin
                // the index is checked before fullness
                if (idx > tbl_count) begin
                    r.status = STAT_RANGE;
                end else if (tbl_count >= TABLE_DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    for (int i = tbl_count; i > idx; i--)
                        tbl_words[i] = tbl_words[i - 1];
                    tbl_words[idx] = word;
                    tbl_count++;
                end
            end
            REQ_POP: begin
                if (tbl_count == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    tbl_count--;
                    r.read_value = tbl_words[tbl_count];
                end
            end
            REQ_DELETE: begin
                if (idx >= tbl_count) begin
                    r.status = STAT_RANGE;
                end else begin
                    for (int i = idx; i + 1 < tbl_count; i++)
                        tbl_words[i] = tbl_words[i + 1];
                    tbl_count--;
                end
            end
            REQ_REMOVE: begin
                // survivors slide down in order
                for (int i = 0; i < tbl_count; i++) begin
                    if (tbl_words[i] == word) begin
                        r.removed_count++;
                    end else begin
                        tbl_words[keep] = tbl_words[i];
                        keep++;
                    end
                end
                tbl_count = keep;
            end
            REQ_FIND: begin
                for (int i = 0; i < tbl_count; i++) begin
                    if (!r.found && tbl_words[i] == word) begin
                        r.found       = 1'b1;
                        r.found_index = i[7:0];
                    end
                end
            end
            REQ_READ: begin
                if (idx >= tbl_count)
                    r.status = STAT_RANGE;
                else
                    r.read_value = tbl_words[idx];
            end
            default: ;
        endcase
        r.count_after = tbl_count[8:0];
        r.is_empty    = (tbl_count == 0);
        return r;
    endfunction

    function automatic logic signed [31:0] pick_word();
        if ($urandom_range(0, 1) == 0)
            return key_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    // ------------------------------------------------------------------------
    // request side: one item per call, start stays high between burst items
    // ------------------------------------------------------------------------
    task automatic send_request(logic [2:0] kind, logic [7:0] idx, logic signed [31:0] word);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = gaps_on ? $urandom_range(0, 15) : 0;
            if (gap != 0) begin
                @(negedge i_clk);
                start = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        start        = 1'b1;
        i_req_type   = kind;
        i_elem_index = idx;
        i_value      = word;
        // item is taken at the first edge that sees busy low
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        table_reply_q.push_back(table_apply(kind, idx, word));
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // reply side: every strobed reply is matched against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : reply_check
        t_table_reply want;
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (table_reply_q.size() == 0) begin
                $error("reply strobed with no item outstanding");
                mismatches++;
            end else begin
                want = table_reply_q.pop_front();
                check_field("status",        32'(want.status),        32'(o_status));
                check_field("read_value",    want.read_value,         o_read_value);
                check_field("found",         32'(want.found),         32'(o_found));
                check_field("found_index",   32'(want.found_index),   32'(o_found_index));
                check_field("removed_count", 32'(want.removed_count), 32'(o_removed_count));
                check_field("count_after",   32'(want.count_after),   32'(o_count_after));
                check_field("is_empty",      32'(want.is_empty),      32'(o_is_empty));
            end
        end
    end

    // stall watchdog: any taken item or strobed reply counts as progress
    initial begin : stall_watch
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((start === 1'b1 && busy === 1'b0) || o_done === 1'b1)
                quiet = 0;
            else
                quiet++;
        end
        $display("ordered_array_table_engine_tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // error paths on an empty table, insert at zero into an empty table,
    // the unused request code
    task automatic test_empty_table();
        send_request(REQ_POP,    8'd0,   32'sd0);
        send_request(REQ_DELETE, 8'd0,   32'sd0);
        send_request(REQ_READ,   8'd0,   32'sd0);
        send_request(REQ_READ,   8'd255, -32'sd1);
        send_request(REQ_REMOVE, 8'd0,   32'sd5);
        send_request(REQ_FIND,   8'd0,   32'sd5);
        send_request(REQ_INSERT, 8'd1,   32'sd7);
        send_request(REQ_INSERT, 8'd0,   32'sd7);
        send_request(REQ_NONE,   8'd0,   32'sd0);
        send_request(REQ_INSERT, 8'd2,   32'sd9);
        send_request(REQ_READ,   8'd0,   32'sd0);
        send_request(REQ_DELETE, 8'd0,   32'sd0);
        send_request(REQ_NONE,   8'd255, -32'sd1);
    endtask

    // word extremes, insert at head and at the end, find hit and miss,
    // delete in the middle, remove all of a repeated word
    task automatic test_word_extremes();
        send_request(REQ_PUSH,   8'd0,   32'sh7fff_ffff);
        send_request(REQ_PUSH,   8'd255, 32'sh8000_0000);
        send_request(REQ_PUSH,   8'd0,   -32'sd1);
        send_request(REQ_PUSH,   8'd0,   32'sd0);
        send_request(REQ_INSERT, 8'd0,   -32'sd1);
        send_request(REQ_INSERT, 8'd5,   32'sd1);
        send_request(REQ_FIND,   8'd0,   -32'sd1);
        send_request(REQ_FIND,   8'd0,   32'sh8000_0000);
        send_request(REQ_FIND,   8'd0,   32'sd12345);
        send_request(REQ_READ,   8'd5,   32'sd0);
        send_request(REQ_READ,   8'd6,   32'sd0);
        send_request(REQ_DELETE, 8'd2,   32'sd0);
        send_request(REQ_REMOVE, 8'd0,   -32'sd1);
        send_request(REQ_POP,    8'd0,   32'sd0);
    endtask

    // fill with random words, then push, insert, read, find, delete, pop and
    // remove around a full table
    task automatic test_full_table();
        while (tbl_count < TABLE_DEPTH)
            send_request(REQ_PUSH, 8'($urandom), pick_word());
        send_request(REQ_PUSH,   8'd0,   32'sd3);
        send_request(REQ_INSERT, 8'd0,   32'sd3);
        send_request(REQ_INSERT, 8'd255, 32'sd3);
        send_request(REQ_READ,   8'd255, 32'sd0);
        send_request(REQ_FIND,   8'd0,   tbl_words[TABLE_DEPTH - 1]);
        send_request(REQ_DELETE, 8'd255, 32'sd0);
        send_request(REQ_INSERT, 8'd255, 32'sh8000_0000);
        send_request(REQ_INSERT, 8'd0,   32'sh7fff_ffff);
        send_request(REQ_DELETE, 8'd0,   32'sd0);
        send_request(REQ_POP,    8'd0,   32'sd0);
        send_request(REQ_FIND,   8'd0,   tbl_words[0]);
        send_request(REQ_REMOVE, 8'd0,   tbl_words[10]);
    endtask

    // weighted random mix; growth outweighs shrinking so the table
    // wanders between empty and full, indexes mostly land in range
    task automatic test_random_mix(int unsigned n_items);
        int unsigned pick;
        int unsigned span;
        logic [7:0]  idx;
        for (int n = 0; n < n_items; n++) begin
            // alternate stretches with and without sender gaps
            if (n % 150 == 0)
                gaps_on = !gaps_on;
            pick = $urandom_range(0, 99);
            span = (tbl_count > 255) ? 255 : tbl_count;
            idx  = 8'($urandom);
            if ($urandom_range(0, 9) != 0) begin
                if (pick < 45)
                    idx = 8'($urandom_range(0, span));
                else if (tbl_count != 0)
                    idx = 8'($urandom_range(0, span - 1));
            end
            if (pick < 30)
                send_request(REQ_PUSH, idx, pick_word());
            else if (pick < 45)
                send_request(REQ_INSERT, idx, pick_word());
            else if (pick < 57)
                send_request(REQ_POP, idx, pick_word());
            else if (pick < 69)
                send_request(REQ_DELETE, idx, pick_word());
            else if (pick < 74)
                send_request(REQ_REMOVE, idx, pick_word());
            else if (pick < 85)
                send_request(REQ_FIND, idx,
                             ($urandom_range(0, 2) == 0 && tbl_count != 0)
                             ? tbl_words[$urandom_range(0, tbl_count - 1)] : pick_word());
            else if (pick < 98)
                send_request(REQ_READ, idx, pick_word());
            else
                send_request(REQ_NONE, idx, pick_word());
        end
    endtask

    // ------------------------------------------------------------------------
    // run
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_req_type   = REQ_PUSH;
        i_elem_index = '0;
        i_value      = '0;
        tbl_count    = 0;
        mismatches   = 0;
        burst_left   = 0;
        gaps_on      = 1'b1;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_table();
        test_word_extremes();
        test_full_table();
        test_random_mix(MIX_ITEMS);

        @(negedge i_clk);
        start = 1'b0;
        // the watchdog bounds this wait
        while (table_reply_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("ordered_array_table_engine_tb: PASS");
        else
            $display("ordered_array_table_engine_tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
